// ----- rtl/unordered_key_list_engine_defines.svh -----
// Assertion macros for the key list engine.
// Each use writes one concurrent assertion clocked on i_clk.
`ifndef UNORDERED_KEY_LIST_ENGINE_DEFINES_SVH
`define UNORDERED_KEY_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define UKLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define UKLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define UKLE_ASSERT(lbl, prop, msg)
`define UKLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/ukle_pkg.sv -----
`default_nettype none

package ukle_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W = 64;
    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REM_FIRST = 3'd2,
        OP_REM_ALL   = 3'd3,
        OP_REM_LONG  = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_COMPACT,
        S_READ,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic scan;
        logic compact;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_end;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/ukle_if.sv -----
`default_nettype none

interface ukle_req_if import ukle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;

    modport source (output valid, operation, key, position, input ready);
    modport sink   (input valid, operation, key, position, output ready);
endinterface

interface ukle_rsp_if import ukle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [CNT_W-1:0] removed_count;
    logic [KEY_W-1:0] read_key;
    logic [CNT_W-1:0] list_size;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, ok, removed_count, read_key, list_size, is_empty, is_full,
                    input ready);
    modport sink   (input valid, ok, removed_count, read_key, list_size, is_empty, is_full,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ukle_ctrl.sv -----
`default_nettype none

module ukle_ctrl import ukle_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_stat           i_stat,
    output logic                 o_ready,
    output t_cmd                 o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_op'(i_op))
                        OP_REM_FIRST: n_state = S_COMPACT;
                        OP_REM_ALL:   n_state = S_COMPACT;
                        OP_REM_LONG:  n_state = S_FIND;
                        OP_READ:      n_state = S_READ;
                        default:      n_state = S_FINISH;
                    endcase
                end
            end
            S_FIND: begin
                if (i_stat.pass_end) n_state = S_COMPACT;
            end
            S_COMPACT: begin
                if (i_stat.pass_end) n_state = S_FINISH;
            end
            S_READ: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load   = i_valid;
            end
            S_FIND: begin
                // The second pass restarts the pointers but keeps the chosen entry.
                if (i_stat.pass_end) begin
                    o_cmd.init = 1'b1;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_COMPACT: begin
                o_cmd.compact = !i_stat.pass_end;
            end
            S_READ: begin
                o_cmd = '0;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ukle_dpath.sv -----
`default_nettype none

module ukle_dpath import ukle_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic             i_rsp_ready,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic                  o_ok,
    output logic [CNT_W-1:0]      o_removed_count,
    output logic [KEY_W-1:0]      o_read_key,
    output logic [CNT_W-1:0]      o_list_size,
    output logic                  o_is_empty,
    output logic                  o_is_full
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Clears the terminating zero byte, everything after it and bytes beyond KEY_BYTES.
    function automatic logic [KEY_W-1:0] f_norm(input logic [KEY_W-1:0] k);
        logic             alive;
        logic [KEY_W-1:0] r;
        alive = 1'b1;
        r     = '0;
        for (int b = 0; b < 8; b++) begin
            alive = alive && (b < KEY_BYTES) && (k[8*b +: 8] != 8'd0);
            if (alive) r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] f_len(input logic [KEY_W-1:0] k);
        logic             alive;
        logic [LEN_W-1:0] n;
        alive = 1'b1;
        n     = '0;
        for (int b = 0; b < 8; b++) begin
            alive = alive && (b < KEY_BYTES) && (k[8*b +: 8] != 8'd0);
            if (alive) n = n + LEN_W'(1);
        end
        return n;
    endfunction

    logic [KEY_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_wr_ptr;
    logic             r_p_vld;
    logic [IDX_W-1:0] r_p_idx;
    logic             r_found;
    logic [CNT_W-1:0] r_removed;
    logic [IDX_W-1:0] r_best;
    logic [LEN_W-1:0] r_best_len;
    logic [KEY_W-1:0] r_rdata;

    logic             r_o_valid;
    logic             r_o_ok;
    logic [CNT_W-1:0] r_o_removed;
    logic [KEY_W-1:0] r_o_key;
    logic [CNT_W-1:0] r_o_size;

    logic             issue;
    logic [IDX_W-1:0] raddr;
    logic [POS_W-1:0] pos_m1;
    logic             match;
    logic             drop;
    logic             full;
    logic             rd_ok;
    logic [LEN_W-1:0] cur_len;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CNT_W-1:0] n_count;
    logic             n_ok;
    logic [CNT_W-1:0] n_removed;
    logic [KEY_W-1:0] n_rkey;

    assign issue   = (i_cmd.scan || i_cmd.compact) && (r_rd_ptr < r_count);
    assign pos_m1  = r_pos - POS_W'(1);
    assign raddr   = issue ? r_rd_ptr[IDX_W-1:0] : pos_m1[IDX_W-1:0];
    assign match   = (r_rdata == r_key);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign rd_ok   = (r_pos != '0) && (CMP_W'(r_pos) <= CMP_W'(r_count));
    assign cur_len = f_len(r_rdata);

    always_comb begin
        case (t_op'(r_op))
            OP_REM_FIRST: drop = match && !r_found;
            OP_REM_ALL:   drop = match;
            OP_REM_LONG:  drop = (r_p_idx == r_best);
            default:      drop = 1'b0;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_ok      = 1'b0;
        n_removed = '0;
        n_rkey    = '0;
        wr_en     = i_cmd.compact && r_p_vld && !drop;
        wr_addr   = r_wr_ptr[IDX_W-1:0];
        wr_data   = r_rdata;
        case (t_op'(r_op))
            OP_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            OP_INSERT: begin
                if (!full) begin
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                    if (i_cmd.finish) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[IDX_W-1:0];
                        wr_data = r_key;
                    end
                end
            end
            OP_REM_FIRST: begin
                n_count = r_wr_ptr;
                n_ok    = r_found;
            end
            OP_REM_ALL: begin
                n_count   = r_wr_ptr;
                n_ok      = r_found;
                n_removed = r_removed;
            end
            OP_REM_LONG: begin
                n_count = r_wr_ptr;
                n_ok    = r_found;
            end
            OP_READ: begin
                n_ok   = rd_ok;
                n_rkey = rd_ok ? r_rdata : '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Reads stay ahead of compaction writes, so a pass never reads a slot it has rewritten.
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= f_norm(i_key);
            r_pos <= i_position;
        end
        if (i_cmd.finish) begin
            r_o_ok      <= n_ok;
            r_o_removed <= n_removed;
            r_o_key     <= n_rkey;
            r_o_size    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_p_vld    <= 1'b0;
            r_p_idx    <= '0;
            r_found    <= 1'b0;
            r_removed  <= '0;
            r_best     <= '0;
            r_best_len <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_p_vld <= issue;
            r_p_idx <= r_rd_ptr[IDX_W-1:0];
            if (issue) r_rd_ptr <= r_rd_ptr + CNT_W'(1);

            if (i_cmd.scan && r_p_vld && (cur_len > r_best_len)) begin
                r_best     <= r_p_idx;
                r_best_len <= cur_len;
            end

            if (i_cmd.compact && r_p_vld) begin
                if (drop) begin
                    r_found   <= 1'b1;
                    r_removed <= r_removed + CNT_W'(1);
                end else begin
                    r_wr_ptr <= r_wr_ptr + CNT_W'(1);
                end
            end

            if (i_cmd.load || i_cmd.init) begin
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_p_vld  <= 1'b0;
            end
            if (i_cmd.load) begin
                r_found    <= 1'b0;
                r_removed  <= '0;
                r_best     <= '0;
                r_best_len <= '0;
            end

            if (i_cmd.finish) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.pass_end = !(r_rd_ptr < r_count) && !r_p_vld;
    assign o_stat.out_free = !r_o_valid || i_rsp_ready;

    assign o_valid         = r_o_valid;
    assign o_ok            = r_o_ok;
    assign o_removed_count = r_o_removed;
    assign o_read_key      = r_o_key;
    assign o_list_size     = r_o_size;
    assign o_is_empty      = (r_o_size == '0);
    assign o_is_full       = (r_o_size == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ----- rtl/unordered_key_list_engine.sv -----
// Unordered key list: up to DEPTH keys of up to eight bytes, kept in insertion order.
// Requests arrive on i_req (operation, key, position) and one response per request
// leaves on o_rsp (ok, removed_count, read_key, list_size, is_empty, is_full); both
// use valid/ready and transfer when both are high.
// One request is worked on at a time. Clear, insert and unused codes need no pass over
// the list; read makes one access to the key store; remove first and remove all make
// one pass over the list, and remove longest makes two.
// The next request is accepted in the cycle after the response is registered.
// The work is bounded by the single read port of the key store: each pass over the
// list reads one entry per cycle, and remove longest needs one pass to find the
// entry and a second to close the gap.
// The response sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following request finishes its work and then
// holds until the waiting response has been taken.
// Reset empties the list and drops any pending response; the key store itself is
// not cleared, as only entries below the size are ever used.
`default_nettype none

`include "unordered_key_list_engine_defines.svh"

module unordered_key_list_engine import ukle_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ukle_req_if.sink   i_req,
    ukle_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    ukle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_op    (i_req.operation),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    ukle_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_req.operation),
        .i_key           (i_req.key),
        .i_position      (i_req.position),
        .i_rsp_ready     (o_rsp.ready),
        .o_stat          (stat),
        .o_valid         (o_rsp.valid),
        .o_ok            (o_rsp.ok),
        .o_removed_count (o_rsp.removed_count),
        .o_read_key      (o_rsp.read_key),
        .o_list_size     (o_rsp.list_size),
        .o_is_empty      (o_rsp.is_empty),
        .o_is_full       (o_rsp.is_full)
    );

    assign i_req.ready = ready;

    `UKLE_ASSERT(a_one_at_a_time, (i_req.valid && i_req.ready) |=> !i_req.ready, "request accepted while busy")
    `UKLE_ASSERT(a_size_bound, o_rsp.valid |-> (o_rsp.list_size <= CNT_W'(DEPTH)), "list size above depth")
    `UKLE_ASSERT(a_removed_ok, (o_rsp.valid && (o_rsp.removed_count != '0)) |-> o_rsp.ok, "removal count without success")
    `UKLE_ASSERT(a_finish_free, cmd.finish |-> stat.out_free, "response overwritten before taken")
    `UKLE_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_rsp.valid, "response valid after reset")

endmodule

`default_nettype wire

// ----- sim/key_list_check.sv -----
`timescale 1ns / 1ps

// Watches both channels of the key list engine. Each accepted request is applied to a
// shadow copy of the list; each accepted response is compared with the oldest
// outstanding prediction.
module key_list_check import ukle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ukle_req_if       i_req,
    ukle_rsp_if       i_rsp,
    output int        o_mismatches,
    output int        o_pending
);

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] removed_count;
        logic [KEY_W-1:0] read_key;
        logic [CNT_W-1:0] list_size;
        logic             is_empty;
        logic             is_full;
    } t_list_response;

    logic [KEY_W-1:0] shadow_keys [DEPTH];
    int               shadow_size;
    t_list_response   predicted_responses [$];
    t_list_response   oldest;

    // Bytes from the first zero byte onwards do not belong to the key.
    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] trimmed;
        bit               ended;
        trimmed = '0;
        ended   = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                trimmed[8*b +: 8] = raw[8*b +: 8];
        end
        return trimmed;
    endfunction

    function automatic int key_length(logic [KEY_W-1:0] k);
        int len;
        len = 0;
        while (len < KEY_BYTES && k[8*len +: 8] != 8'd0)
            len++;
        return len;
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < shadow_size; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_size--;
    endfunction

    function automatic t_list_response apply_request(logic [OP_W-1:0] code,
                                                     logic [KEY_W-1:0] raw_key,
                                                     logic [POS_W-1:0] pos);
        t_list_response   r;
        logic [KEY_W-1:0] k;
        int               idx;
        int               best;
        r = '0;
        k = trim_key(raw_key);
        case (code)
            OP_CLEAR: begin
                shadow_size = 0;
                r.ok = 1'b1;
            end
            OP_INSERT: begin
                if (shadow_size < DEPTH) begin
                    shadow_keys[shadow_size] = k;
                    shadow_size++;
                    r.ok = 1'b1;
                end
            end
            OP_REM_FIRST: begin
                for (idx = 0; idx < shadow_size; idx++) begin
                    if (shadow_keys[idx] == k) begin
                        drop_entry(idx);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            OP_REM_ALL: begin
                idx = 0;
                while (idx < shadow_size) begin
                    if (shadow_keys[idx] == k) begin
                        drop_entry(idx);
                        r.removed_count++;
                    end else begin
                        idx++;
                    end
                end
                r.ok = (r.removed_count != '0);
            end
            OP_REM_LONG: begin
                if (shadow_size > 0) begin
                    best = 0;
                    for (idx = 1; idx < shadow_size; idx++)
                        if (key_length(shadow_keys[idx]) > key_length(shadow_keys[best]))
                            best = idx;
                    drop_entry(best);
                    r.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (pos >= 1 && pos <= shadow_size) begin
                    r.ok       = 1'b1;
                    r.read_key = shadow_keys[pos - 1];
                end
            end
            default: begin
            end
        endcase
        r.list_size = CNT_W'(shadow_size);
        r.is_empty  = (shadow_size == 0);
        r.is_full   = (shadow_size == DEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        shadow_size  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_size = 0;
            predicted_responses.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (predicted_responses.size() == 0) begin
                    $display("%0t: response with no request outstanding, expected none, got %p",
                             $time, {i_rsp.ok, i_rsp.removed_count, i_rsp.read_key,
                                     i_rsp.list_size, i_rsp.is_empty, i_rsp.is_full});
                    o_mismatches++;
                end else begin
                    oldest = predicted_responses.pop_front();
                    check_field("ok", oldest.ok, i_rsp.ok);
                    check_field("removed_count", oldest.removed_count, i_rsp.removed_count);
                    check_field("read_key", oldest.read_key, i_rsp.read_key);
                    check_field("list_size", oldest.list_size, i_rsp.list_size);
                    check_field("is_empty", oldest.is_empty, i_rsp.is_empty);
                    check_field("is_full", oldest.is_full, i_rsp.is_full);
                end
            end
            if (i_req.valid && i_req.ready)
                predicted_responses.push_back(apply_request(i_req.operation, i_req.key,
                                                            i_req.position));
        end
        o_pending = predicted_responses.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ukle_pkg::*;

    localparam int RANDOM_ITEMS = 920;
    localparam int POOL_SIZE    = 6;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_START   = 300;
    localparam int HOLD_ITEMS   = 40;
    localparam int QUIET_ITEMS  = 120;
    localparam int STALL_LIMIT  = 4000;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   quiet_cycles;
    bit   long_hold_req;
    bit   long_hold_done;
    bit   no_idling;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    ukle_req_if req_ch ();
    ukle_rsp_if rsp_ch ();

    unordered_key_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    key_list_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A string of random non-zero bytes, zero padded.
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(0, KEY_BYTES);
        for (int b = 0; b < len; b++)
            k[8*b +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Fills the bytes after the terminating zero with rubbish, which must not matter.
    function automatic logic [KEY_W-1:0] pad_after_end(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] padded;
        bit               ended;
        padded = k;
        ended  = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (ended)
                padded[8*b +: 8] = 8'($urandom);
            else if (k[8*b +: 8] == 8'd0)
                ended = 1'b1;
        end
        return padded;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 2) == 0)
                k = pad_after_end(k);
        end else if (roll < 9) begin
            k = make_key();
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, DEPTH + 1));
    endfunction

    // Filling phases favour inserts; draining phases favour the removals.
    function automatic logic [OP_W-1:0] pick_operation(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_CLEAR;
        if (roll < 4)
            return OP_W'($urandom_range(6, 7));
        if (filling) begin
            if (roll < 60) return OP_INSERT;
            if (roll < 75) return OP_READ;
            if (roll < 85) return OP_REM_FIRST;
            if (roll < 93) return OP_REM_ALL;
            return OP_REM_LONG;
        end
        if (roll < 30) return OP_INSERT;
        if (roll < 45) return OP_READ;
        if (roll < 65) return OP_REM_FIRST;
        if (roll < 80) return OP_REM_ALL;
        return OP_REM_LONG;
    endfunction

    function automatic logic [KEY_W-1:0] directed_key(int n);
        case (n)
            0:       return '0;
            1:       return '1;
            2:       return 64'hFFFF_FF00_0000_4142;
            3:       return 64'h8877_6655_4433_2211;
            default: return (n % 3 == 0) ? 64'h0000_0000_0000_4142 : make_key();
        endcase
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = make_key();
    endtask

    // Called at a falling edge; returns at the falling edge after the request was taken.
    task automatic send_request(logic [OP_W-1:0] code, logic [KEY_W-1:0] k,
                                logic [POS_W-1:0] pos);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= code;
        req_ch.key       <= k;
        req_ch.position  <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause_requests(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Receiver: random runs of ready and stalls, one long hold-off on request.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else if (no_idling || $urandom_range(0, 2) != 0) begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        bit filling;
        int n;
        quiet_cycles     = 0;
        long_hold_req    = 1'b0;
        long_hold_done   = 1'b0;
        no_idling        = 1'b0;
        filling          = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_CLEAR;
        req_ch.key       = '0;
        req_ch.position  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Removals and a read on the empty list.
        send_request(OP_REM_FIRST, 64'h4142, '0);
        send_request(OP_REM_ALL, 64'h4142, '0);
        send_request(OP_REM_LONG, '0, '0);
        send_request(OP_READ, '0, POS_W'(1));
        // Fill to the brim, then try one more insert.
        for (n = 0; n < DEPTH; n++)
            send_request(OP_INSERT, directed_key(n), '0);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_READ, '0, POS_W'(DEPTH));
        send_request(OP_READ, '0, POS_W'(DEPTH + 1));
        send_request(OP_W'(6), '1, '1);
        send_request(OP_REM_ALL, 64'hAAAA_0000_4142, '0);
        send_request(OP_REM_FIRST, 64'h5A5A_5A5A_5A5A_5A5A, '0);
        send_request(OP_REM_LONG, '0, '0);
        send_request(OP_CLEAR, '1, '1);

        refresh_pool();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 48 == 0)
                filling = !filling;
            if (n % 150 == 149)
                refresh_pool();
            if (n == HOLD_START)
                long_hold_req = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                no_idling = 1'b1;
            send_request(pick_operation(filling), pick_key(), pick_position());
            // The sender keeps offering while the receiver is held off.
            if (!no_idling && !(n >= HOLD_START && n < HOLD_START + HOLD_ITEMS)
                    && $urandom_range(0, 3) == 0)
                pause_requests($urandom_range(1, 15));
        end
        req_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- unordered_key_list_engine.f -----
+incdir+rtl
rtl/ukle_pkg.sv
rtl/ukle_if.sv
rtl/ukle_ctrl.sv
rtl/ukle_dpath.sv
rtl/unordered_key_list_engine.sv
sim/key_list_check.sv
sim/tb_top.sv
